>>> sv/jsk_pkg.sv
package jsk_pkg;

   // Number of converter bits that take part in calibration and mapping.
   localparam int SAMPLE_BITS = 10;
   // Width of the sample fields on the request.
   localparam int FIELD_W     = 10;
   localparam int OUT_W       = 8;
   localparam int BTN_W       = 5;
   localparam int DZ_W        = 7;
   localparam int LANES       = 3;
   localparam int NUM_W       = SAMPLE_BITS + OUT_W;
   localparam int DIV_STEPS   = OUT_W;
   localparam int CNT_W       = $clog2(DIV_STEPS);
   localparam int OUT_OFFSET  = 2 ** (OUT_W - 1);

   localparam int LANE_HOR = 0;
   localparam int LANE_VER = 1;
   localparam int LANE_ROT = 2;

   localparam logic [DZ_W-1:0] DEADZONE_RESET = DZ_W'(15);

   localparam logic [SAMPLE_BITS-1:0] LOW_RESET [LANES] = '{
      SAMPLE_BITS'(190), SAMPLE_BITS'(190), SAMPLE_BITS'(50)};
   localparam logic [SAMPLE_BITS-1:0] HIGH_RESET [LANES] = '{
      SAMPLE_BITS'(810), SAMPLE_BITS'(810), SAMPLE_BITS'(950)};

   typedef struct packed {
      logic [FIELD_W-1:0] hor_sample;
      logic [FIELD_W-1:0] ver_sample;
      logic [FIELD_W-1:0] rot_sample;
      logic               right_handed;
      logic [BTN_W-1:0]   button_levels;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] hor_out;
      logic signed [OUT_W-1:0] ver_out;
      logic signed [OUT_W-1:0] rot_out;
      logic [BTN_W-1:0]        button_mask;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WIDEN,
      ST_SETUP,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic widen;
      logic setup;
      logic div_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

>>> sv/joystick_axis_calibrate_map.sv
// A request is taken only while idle, then widened, set up, divided by the eight-step restoring divider per axis
// and mapped into the output register once that register is free; only then is the next request taken.
// A finished response waits in the output register while the next request is taken.
// Reset (synchronous, active high) restores the travel bounds and the deadzone of 15,
// and empties the output register.
module joystick_axis_calibrate_map (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  jsk_pkg::req_type          req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output jsk_pkg::rsp_type          rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [jsk_pkg::DZ_W-1:0] csr_data
);
   import jsk_pkg::*;

   // Commands from the sequencer to the datapath, and the divider's end-of-run flag back.
   cmd_type    cmd;
   status_type status;

   // The controller walks each request through capture, bound widening, numerator
   // set-up, the division steps and the final mapping into the output register.
   jsk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // The datapath holds the three axis lanes side by side. Each lane widens its bounds,
   // forms 255 times the offset from the low bound (mirrored for the horizontal and
   // vertical axes in right-handed mode), divides by the span one quotient bit per cycle
   // and then turns quotient and remainder into the truncated, deadzoned output.
   jsk_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_data (req_data),
      .dz_write (csr_valid && csr_ready),
      .dz_value (csr_data),
      .rsp_data (rsp_data)
   );

endmodule

>>> sv/jsk_ctrl.sv
module jsk_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               csr_ready,
   output jsk_pkg::cmd_type    cmd,
   input  jsk_pkg::status_type status
);
   import jsk_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   // The output register may be refilled when empty or being taken now.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_WIDEN;
         ST_WIDEN:  state_in = ST_SETUP;
         ST_SETUP:  state_in = ST_DIVIDE;
         ST_DIVIDE: if (status.div_last) state_in = ST_DONE;
         ST_DONE:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      csr_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            csr_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_WIDEN:  cmd.widen    = 1'b1;
         ST_SETUP:  cmd.setup    = 1'b1;
         ST_DIVIDE: cmd.div_step = 1'b1;
         ST_DONE:   cmd.load_rsp = rsp_free;
         default:   cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/jsk_dp.sv
module jsk_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  jsk_pkg::cmd_type           cmd,
   output jsk_pkg::status_type        status,
   input  jsk_pkg::req_type           req_data,
   input  logic                      dz_write,
   input  logic [jsk_pkg::DZ_W-1:0]  dz_value,
   output jsk_pkg::rsp_type           rsp_data
);
   import jsk_pkg::*;

   logic [SAMPLE_BITS-1:0] smp_ff  [LANES];
   logic [SAMPLE_BITS-1:0] low_ff  [LANES];
   logic [SAMPLE_BITS-1:0] low_in  [LANES];
   logic [SAMPLE_BITS-1:0] high_ff [LANES];
   logic [SAMPLE_BITS-1:0] high_in [LANES];
   logic [SAMPLE_BITS-1:0] den_ff  [LANES];
   logic [SAMPLE_BITS-1:0] den_in  [LANES];
   logic [SAMPLE_BITS-1:0] rem_ff  [LANES];
   logic [SAMPLE_BITS-1:0] rem_in  [LANES];
   logic [OUT_W-1:0]       quo_ff  [LANES];
   logic [OUT_W-1:0]       quo_in  [LANES];
   logic [OUT_W-1:0]       map_res [LANES];
   logic [SAMPLE_BITS-1:0] diff    [LANES];
   logic [NUM_W-1:0]       num     [LANES];
   logic [SAMPLE_BITS:0]   shifted [LANES];
   logic [SAMPLE_BITS:0]   trial   [LANES];
   logic                   fits    [LANES];
   logic                   mirror_ff;
   logic [BTN_W-1:0]       mask_ff;
   logic [DZ_W-1:0]        deadzone_ff;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   rsp_type                rsp_ff;

   localparam logic signed [OUT_W:0] V_MIN = -(OUT_W + 1)'(OUT_OFFSET);
   localparam logic signed [OUT_W:0] V_OFF = (OUT_W + 1)'(OUT_OFFSET);

   // Truncating map: v = q - 128, plus one when below the centre and inexact.
   function automatic logic [OUT_W-1:0] map_lane(
      input logic [OUT_W-1:0]       q,
      input logic [SAMPLE_BITS-1:0] r,
      input logic [SAMPLE_BITS-1:0] d,
      input logic [DZ_W-1:0]        dz
   );
      logic signed [OUT_W:0] v;
      logic signed [OUT_W:0] dzs;
      logic                  up;
      up  = !q[OUT_W-1] && (r != '0);
      dzs = $signed({2'b00, dz});
      v   = $signed({1'b0, q}) - V_OFF + $signed({{OUT_W{1'b0}}, up});
      if (d == '0) begin
         v = V_MIN;
      end
      if (v >= -dzs && v <= dzs) begin
         v = '0;
      end
      return v[OUT_W-1:0];
   endfunction

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         low_in[i]  = low_ff[i];
         high_in[i] = high_ff[i];
         if (smp_ff[i] > high_ff[i]) begin
            high_in[i] = smp_ff[i];
         end else if (smp_ff[i] < low_ff[i]) begin
            low_in[i] = smp_ff[i];
         end
         if (mirror_ff && i != LANE_ROT) begin
            diff[i] = high_ff[i] - smp_ff[i];
         end else begin
            diff[i] = smp_ff[i] - low_ff[i];
         end
         // 255 * diff as a shift and a subtraction.
         num[i] = {diff[i], {OUT_W{1'b0}}} - {{OUT_W{1'b0}}, diff[i]};
         shifted[i] = {rem_ff[i], quo_ff[i][OUT_W-1]};
         trial[i]   = shifted[i] - {1'b0, den_ff[i]};
         fits[i]    = shifted[i] >= {1'b0, den_ff[i]};
         den_in[i]  = den_ff[i];
         rem_in[i]  = rem_ff[i];
         quo_in[i]  = quo_ff[i];
         if (cmd.setup) begin
            den_in[i] = high_ff[i] - low_ff[i];
            rem_in[i] = num[i][NUM_W-1:OUT_W];
            quo_in[i] = num[i][OUT_W-1:0];
         end else if (cmd.div_step) begin
            rem_in[i] = fits[i] ? trial[i][SAMPLE_BITS-1:0] : shifted[i][SAMPLE_BITS-1:0];
            quo_in[i] = {quo_ff[i][OUT_W-2:0], fits[i]};
         end
         map_res[i] = map_lane(quo_ff[i], rem_ff[i], den_ff[i], deadzone_ff);
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.setup) begin
         cnt_in = '0;
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   assign status.div_last = (cnt_ff == CNT_W'(DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff <= DEADZONE_RESET;
         for (int i = 0; i < LANES; i++) begin
            low_ff[i]  <= LOW_RESET[i];
            high_ff[i] <= HIGH_RESET[i];
         end
      end else begin
         if (dz_write) begin
            deadzone_ff <= dz_value;
         end
         if (cmd.widen) begin
            for (int i = 0; i < LANES; i++) begin
               low_ff[i]  <= low_in[i];
               high_ff[i] <= high_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      for (int i = 0; i < LANES; i++) begin
         den_ff[i] <= den_in[i];
         rem_ff[i] <= rem_in[i];
         quo_ff[i] <= quo_in[i];
      end
      if (cmd.capture) begin
         smp_ff[LANE_HOR] <= SAMPLE_BITS'(req_data.hor_sample);
         smp_ff[LANE_VER] <= SAMPLE_BITS'(req_data.ver_sample);
         smp_ff[LANE_ROT] <= SAMPLE_BITS'(req_data.rot_sample);
         mirror_ff        <= req_data.right_handed;
         mask_ff          <= ~req_data.button_levels;
      end
      if (cmd.load_rsp) begin
         rsp_ff.hor_out     <= $signed(map_res[LANE_HOR]);
         rsp_ff.ver_out     <= $signed(map_res[LANE_VER]);
         rsp_ff.rot_out     <= $signed(map_res[LANE_ROT]);
         rsp_ff.button_mask <= mask_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> sv/jsk_checker.sv
module jsk_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input jsk_pkg::req_type          req_data,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input jsk_pkg::rsp_type          rsp_data,
   input logic                     csr_valid,
   input logic                     csr_ready,
   input logic [jsk_pkg::DZ_W-1:0] csr_data
);
   import jsk_pkg::*;

   // A stalled response keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Reset leaves the output register empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

   // One request at a time: an accepted request closes the input for the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in progress");

   // A new response only appears while a request is being worked on.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared with no request in progress");

endmodule

bind joystick_axis_calibrate_map jsk_checker u_jsk_checker (.*);
